// ----- sv/ecgmp_pkg.sv -----
// Shared types and sizes for the ECG morphological preprocessing block.
package ecgmp_pkg;
	localparam int LP_DEPTH  = 256;
	localparam int WIN_DEPTH = 1024;
	localparam int MH_DEPTH  = 512;
	localparam int LP_AW     = $clog2(LP_DEPTH);
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int MH_AW     = $clog2(MH_DEPTH);

	localparam logic [7:0] N_MAX = 8'(LP_DEPTH / 2);

	typedef enum logic [1:0] {
		REG_LP_HALF = 2'd0,
		REG_SCALE   = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]       val;
		logic [WIN_AW-1:0] stamp;
	} dq_ent_t;

	typedef struct packed {
		logic              start;
		logic              is_max;
		logic [WIN_AW-1:0] stamp;
		logic [WIN_AW-1:0] win;
	} dq_ctl_t;
endpackage

// ----- sv/ecgmp_deque.sv -----
// Monotonic deque for the sliding max or min, held in one synchronous RAM.
module ecgmp_deque import ecgmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dq_ctl_t     ctl,
	input  logic [31:0] value,
	output logic        busy,
	output logic [31:0] head_val
);
	typedef enum logic [2:0] {
		D_IDLE, D_RD, D_CMP, D_WR, D_RDH, D_CHK, D_RDV, D_OUT
	} dstate_t;

	dstate_t           state_q;
	dq_ent_t           mem [WIN_DEPTH];
	dq_ent_t           rdata_q;
	logic [WIN_AW-1:0] head_q;
	logic [WIN_AW:0]   count_q;
	logic [WIN_AW:0]   j_q;
	logic [31:0]       v_q;
	logic [31:0]       head_val_q;
	logic [WIN_AW-1:0] st_q;
	logic [WIN_AW-1:0] win_q;
	logic              max_q;
	logic [WIN_AW-1:0] raddr;
	logic [WIN_AW-1:0] waddr;
	logic              drop;

	assign waddr = head_q + j_q[WIN_AW-1:0];

	always_comb begin
		case (state_q)
			D_RD:    raddr = head_q + j_q[WIN_AW-1:0] - 1'b1;
			default: raddr = head_q;
		endcase
	end

	// new value pops entries it equals or beats
	assign drop = max_q ? ($signed(v_q) >= $signed(rdata_q.val))
	                    : ($signed(rdata_q.val) >= $signed(v_q));

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (state_q == D_WR) begin
			mem[waddr] <= '{val: v_q, stamp: st_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= D_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			j_q        <= '0;
			v_q        <= '0;
			st_q       <= '0;
			win_q      <= '0;
			max_q      <= 1'b0;
			head_val_q <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (ctl.start) begin
						v_q   <= value;
						st_q  <= ctl.stamp;
						win_q <= ctl.win;
						max_q <= ctl.is_max;
						j_q   <= count_q;
						state_q <= (count_q == '0) ? D_WR : D_RD;
					end
				end
				D_RD:  state_q <= D_CMP;
				D_CMP: begin
					if (drop) begin
						j_q     <= j_q - 1'b1;
						state_q <= (j_q == (WIN_AW+1)'(1)) ? D_WR : D_RD;
					end else begin
						state_q <= D_WR;
					end
				end
				D_WR: begin
					count_q <= j_q + 1'b1;
					state_q <= D_RDH;
				end
				D_RDH: state_q <= D_CHK;
				D_CHK: begin
					if (count_q > {1'b0, win_q} || rdata_q.stamp == st_q - win_q) begin
						head_q  <= head_q + 1'b1;
						count_q <= count_q - 1'b1;
					end
					state_q <= D_RDV;
				end
				D_RDV: state_q <= D_OUT;
				D_OUT: begin
					head_val_q <= rdata_q.val;
					state_q    <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != D_IDLE);
	assign head_val = head_val_q;
endmodule

// ----- sv/ecg_morphological_preprocess.sv -----
// Top level: comb low-pass, morphological derivative and Laplacian for ECG.
//  channel | signals                                   | dir
//  in      | in_valid, in_ready, ecg_sample            | in
//  out     | out_valid, out_ready, morph_value, lap... | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
// One item at a time: the low-pass runs through S_LPA, S_LPB and S_LPC, then the two
// deques run side by side, each walking its compared entries (D_RD, D_CMP) and then
// D_WR, D_RDH, D_CHK, D_RDV and D_OUT; S_MW waits for both, S_FIN is the final step,
// and the FSM returns to S_IDLE before the next accept. The pop walk sets the item time.
// Reset empties the deques and zeroes histories (via fill counts); no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile
// and only its final step waits for the output register to free.
module ecg_morphological_preprocess import ecgmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] ecg_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] morph_value,
	output logic [31:0] laplacian_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_LPA, S_LPB, S_LPC, S_MW, S_FIN} state_t;

	state_t            state_q;
	logic [7:0]        lp_half_q;
	logic [8:0]        scale_q;
	logic [7:0]        n_q;
	logic [8:0]        s_q;
	logic [15:0]       x_q;
	logic [15:0]       lp_mem [LP_DEPTH];
	logic [15:0]       lp_rdata_q;
	logic [LP_AW-1:0]  lp_raddr;
	logic [LP_AW-1:0]  lp_pos_q;
	logic [LP_AW:0]    lp_fill_q;
	logic [15:0]       lp_a_q;
	logic [31:0]       lp1_q, lp2_q, lp_q, lp_new;
	logic [31:0]       mh_mem [MH_DEPTH];
	logic [31:0]       mh_rdata_q;
	logic [MH_AW-1:0]  mh_pos_q;
	logic [MH_AW:0]    mh_fill_q;
	logic              mh_ok_q;
	logic [31:0]       delayed_q, lap0_q, lap1_q, m_val, lap_val;
	logic [WIN_AW-1:0] idx_q;
	logic [31:0]       morph_q, lapo_q;
	logic              out_valid_q;
	logic [15:0]       lp_b;
	logic              a_ok, b_ok;
	dq_ctl_t           ctl_max, ctl_min;
	logic              busy_max, busy_min;
	logic [31:0]       hi, lo;
	logic [8:0]        n2;
	logic              fin_go;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign n2        = {n_q, 1'b0};

	// history reads beyond the fill count see the reset zero
	assign a_ok = ({1'b0, n_q} <= lp_fill_q);
	assign b_ok = (n2 <= lp_fill_q);
	assign lp_b = b_ok ? lp_rdata_q : 16'd0;

	always_comb begin
		case (state_q)
			S_LPA:   lp_raddr = lp_pos_q - n_q;
			default: lp_raddr = lp_pos_q - n2[LP_AW-1:0];
		endcase
	end

	assign lp_new = {{16{x_q[15]}}, x_q} - {{15{lp_a_q[15]}}, lp_a_q, 1'b0}
	              + {{16{lp_b[15]}}, lp_b} + {lp1_q[30:0], 1'b0} - lp2_q;

	always_ff @(posedge clk) begin
		lp_rdata_q <= lp_mem[lp_raddr];
		if (state_q == S_LPC) begin
			lp_mem[lp_pos_q] <= x_q;
		end
	end

	always_ff @(posedge clk) begin
		mh_rdata_q <= mh_mem[mh_pos_q - s_q];
		if (fin_go) begin
			mh_mem[mh_pos_q] <= lp_q;
		end
	end

	always_comb begin
		ctl_max.start  = (state_q == S_LPC);
		ctl_max.is_max = 1'b1;
		ctl_max.stamp  = idx_q;
		ctl_max.win    = {s_q, 1'b1};
		ctl_min        = ctl_max;
		ctl_min.is_max = 1'b0;
	end

	ecgmp_deque u_max (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_max), .value(lp_new),
		.busy(busy_max), .head_val(hi)
	);
	ecgmp_deque u_min (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_min), .value(lp_new),
		.busy(busy_min), .head_val(lo)
	);

	assign m_val   = hi + lo - (mh_ok_q ? {mh_rdata_q[30:0], 1'b0} : 32'd0);
	assign lap_val = m_val - {lap0_q[30:0], 1'b0} + lap1_q;
	assign fin_go  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lp_half_q   <= 8'd6;
			scale_q     <= 9'd21;
			n_q         <= 8'd1;
			s_q         <= 9'd1;
			x_q         <= '0;
			lp_pos_q    <= '0;
			lp_fill_q   <= '0;
			lp_a_q      <= '0;
			lp1_q       <= '0;
			lp2_q       <= '0;
			lp_q        <= '0;
			mh_pos_q    <= '0;
			mh_fill_q   <= '0;
			mh_ok_q     <= 1'b0;
			delayed_q   <= '0;
			lap0_q      <= '0;
			lap1_q      <= '0;
			idx_q       <= '0;
			morph_q     <= '0;
			lapo_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_LP_HALF: lp_half_q <= cfg_data[7:0];
					REG_SCALE:   scale_q   <= cfg_data;
					default:     ;
				endcase
			end
			// a new result refills the register in the cycle the old one leaves
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q <= ecg_sample;
						n_q <= (lp_half_q == 8'd0) ? 8'd1
						     : (lp_half_q > N_MAX) ? N_MAX : lp_half_q;
						s_q <= (scale_q == 9'd0) ? 9'd1 : scale_q;
						state_q <= S_LPA;
					end
				end
				S_LPA: state_q <= S_LPB;
				S_LPB: begin
					lp_a_q  <= a_ok ? lp_rdata_q : 16'd0;
					state_q <= S_LPC;
				end
				S_LPC: begin
					lp_q     <= lp_new;
					lp2_q    <= lp1_q;
					lp1_q    <= lp_new;
					lp_pos_q <= lp_pos_q + 1'b1;
					if (lp_fill_q != (LP_AW+1)'(LP_DEPTH)) begin
						lp_fill_q <= lp_fill_q + 1'b1;
					end
					mh_ok_q <= ({1'b0, s_q} <= mh_fill_q);
					state_q <= S_MW;
				end
				S_MW: begin
					if (!busy_max && !busy_min) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						morph_q     <= delayed_q;
						lapo_q      <= lap_val;
						delayed_q   <= m_val;
						lap1_q      <= lap0_q;
						lap0_q      <= m_val;
						mh_pos_q    <= mh_pos_q + 1'b1;
						if (mh_fill_q != (MH_AW+1)'(MH_DEPTH)) begin
							mh_fill_q <= mh_fill_q + 1'b1;
						end
						idx_q   <= idx_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign morph_value     = morph_q;
	assign laplacian_value = lapo_q;
endmodule

// ----- sv/ecgmp_checker.sv -----
// Port-level checks for the ECG preprocessing block, bound to the top level.
module ecgmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] morph_value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(morph_value))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && $past(!in_ready))
		else $error("result appeared without an item in work");
endmodule

bind ecg_morphological_preprocess ecgmp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .morph_value(morph_value)
);
